@@ src/nabump_pkg.sv @@
// Package with the shared types, constants and codes of the node arena bump allocator.
package nabump_pkg;

   localparam int DefArenas = 16;
   localparam int DefNodes  = 256;

   localparam logic [7:0]  NoArena   = 8'hFF;
   localparam logic [15:0] NoOffset  = 16'hFFFF;
   localparam logic [15:0] HeapFail  = 16'hFFFF;
   localparam logic [15:0] SysOwner  = 16'hFFFF;
   localparam logic [15:0] SizeMax   = 16'd65532;

   typedef enum logic [3:0] {
      OP_CREATE     = 4'd0,
      OP_DESTROY    = 4'd1,
      OP_SET_ACTIVE = 4'd2,
      OP_CAPTURE    = 4'd3,
      OP_ALLOC      = 4'd4,
      OP_RESET      = 4'd5,
      OP_WR_ARENA   = 4'd6,
      OP_WR_OFFSET  = 4'd7,
      OP_READ_NODE  = 4'd8,
      OP_USAGE      = 4'd9
   } op_type;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_ZERO_SIZE  = 4'd1,
      ST_BAD_NODE   = 4'd2,
      ST_IDS_FULL   = 4'd3,
      ST_NO_ALLOC   = 4'd4,
      ST_BAD_ARENA  = 4'd5,
      ST_EXHAUSTED  = 4'd6,
      ST_ARENA0     = 4'd7,
      ST_NOT_OWNER  = 4'd8,
      ST_HEAP_FAIL  = 4'd9
   } status_type;

   localparam logic [1:0] CSR_NODE_COUNT  = 2'd0;
   localparam logic [1:0] CSR_ARENA0_BASE = 2'd1;
   localparam logic [1:0] CSR_ARENA0_SIZE = 2'd2;

   typedef struct packed {
      logic [3:0]  operation;
      logic [15:0] node_id;
      logic [15:0] byte_count;
      logic [2:0]  align_log2;
      logic [15:0] heap_index;
      logic [31:0] base_address;
      logic [7:0]  arena_id;
      logic [15:0] write_value;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  result_arena;
      logic [31:0] address;
      logic [15:0] offset;
      logic [15:0] used_bytes;
      logic [15:0] free_bytes;
      logic [15:0] free_heap_index;
      logic        free_valid;
      logic        last;
   } rsp_type;

   // Rounds a size up to a multiple of four, saturating at the largest one.
   function automatic logic [15:0] round4(input logic [15:0] v);
      logic [16:0] s;
      begin
         s = {1'b0, v} + 17'd3;
         if (v > SizeMax) return SizeMax;
         return {s[15:2], 2'b00};
      end
   endfunction

endpackage

@@ src/nabump_if.sv @@
// Valid-ready channel interfaces for requests, results and register writes.
interface nabump_req_if;
   import nabump_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface nabump_rsp_if;
   import nabump_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface nabump_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/node_arena_bump_allocator.sv @@
// Top level of the node arena bump allocator with its sequencer and tables.
//
//   channel  dir  handshake    carries
//   req      in   valid/ready  one request
//   rsp      out  valid/ready  one or more results, last marks the end
//   csr      in   valid/ready  register index and data
//
// A simple request passes node table read, execute, result and the
// return to idle. Create adds a search of up to ARENAS arena ids.
// Destroy and reset sweep the node table one entry a cycle, and reset
// also walks the arena table one entry a cycle, held while it emits a
// result. After reset the node table is cleared by a sweep of all entries
// before the first request is taken. A stalled result holds the sequencer.
module node_arena_bump_allocator #(
   parameter int ARENAS = nabump_pkg::DefArenas,
   parameter int NODES  = nabump_pkg::DefNodes
) (
   input logic clock,
   input logic reset,
   nabump_req_if.sink   req,
   nabump_rsp_if.source rsp,
   nabump_csr_if.sink   csr
);
   import nabump_pkg::*;

   localparam int AW = $clog2(ARENAS);
   localparam int NW = $clog2(NODES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SEARCH, S_SWEEP, S_RSCAN, S_RSWEEP, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   req_type     r_ff, r_in;
   rsp_type     out_ff, out_in;
   logic [NW:0] cnt_ff, cnt_in;
   logic [AW-1:0] aidx_ff, aidx_in;
   logic [AW:0]   scan_ff, scan_in;
   logic [8:0]  node_count_ff, node_count_in;
   logic [7:0]  next_id_ff, next_id_in;
   logic [7:0]  active_ff, active_in;

   logic [ARENAS-1:0] valid_ff, valid_in;
   logic [31:0] base_ff [ARENAS];
   logic [15:0] heap_ff [ARENAS];
   logic [15:0] size_ff [ARENAS];
   logic [15:0] used_ff [ARENAS];
   logic [15:0] owner_ff [ARENAS];

   logic [7:0]  amap [NODES];
   logic [15:0] omap [NODES];
   logic [7:0]  amap_rd_ff;
   logic [15:0] omap_rd_ff;

   logic          mem_we;
   logic [NW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wa;
   logic [15:0]   mem_wo;
   logic          mem_wa_en, mem_wo_en;

   logic          arena_we;
   logic [AW-1:0] arena_wsel;
   logic [31:0]   arena_wbase;
   logic [15:0]   arena_wheap, arena_wsize, arena_wused, arena_wowner;
   logic          used_we;
   logic [AW-1:0] used_wsel;
   logic [15:0]   used_wval;

   logic [15:0] bound;
   logic        node_ok;
   logic [NW-1:0] node_ix;
   logic [AW-1:0] sel;
   logic        sel_ok;
   logic [7:0]  cand_sum;
   logic [AW-1:0] cand;
   logic [31:0] al_addr;
   logic [15:0] al_off, al_used;
   logic        al_fits;
   logic [AW-1:0] map_sel;

   assign bound   = ({7'd0, node_count_ff} < 16'(NODES)) ? {7'd0, node_count_ff} : 16'(NODES);
   assign node_ok = r_ff.node_id < bound;
   assign node_ix = r_ff.node_id[NW-1:0];
   assign sel     = r_ff.arena_id[AW-1:0];
   assign sel_ok  = (r_ff.arena_id < 8'(ARENAS)) && valid_ff[sel];
   assign map_sel = amap_rd_ff[AW-1:0];
   assign cand_sum = next_id_ff + 8'(scan_ff);
   assign cand    = (cand_sum >= 8'(ARENAS)) ? AW'(cand_sum - 8'(ARENAS)) : AW'(cand_sum);

   nabump_align u_align (
      .base       (base_ff[map_sel]),
      .used       (used_ff[map_sel]),
      .size       (size_ff[map_sel]),
      .req_size   (r_ff.byte_count),
      .align_log2 (r_ff.align_log2),
      .aligned    (al_addr),
      .off        (al_off),
      .new_used   (al_used),
      .fits       (al_fits)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.payload = out_ff;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (mem_we && mem_wa_en) amap[mem_waddr] <= mem_wa;
      if (mem_we && mem_wo_en) omap[mem_waddr] <= mem_wo;
      amap_rd_ff <= amap[mem_raddr];
      omap_rd_ff <= omap[mem_raddr];
   end

   function automatic rsp_type mk(input logic [3:0] st);
      rsp_type o;
      begin
         o = '0;
         o.status = st;
         o.result_arena = NoArena;
         o.last = 1'b1;
         return o;
      end
   endfunction

   function automatic logic [15:0] free_of(input logic [15:0] u, input logic [15:0] s);
      begin
         return (u > s) ? 16'd0 : 16'(s - u);
      end
   endfunction

   always_comb begin
      state_in = state_ff;
      r_in = r_ff;
      out_in = out_ff;
      cnt_in = cnt_ff;
      aidx_in = aidx_ff;
      scan_in = scan_ff;
      next_id_in = next_id_ff;
      active_in = active_ff;
      valid_in = valid_ff;
      mem_we = 1'b0;
      mem_wa_en = 1'b0;
      mem_wo_en = 1'b0;
      mem_waddr = node_ix;
      mem_raddr = node_ix;
      mem_wa = 8'd0;
      mem_wo = NoOffset;
      arena_we = 1'b0;
      arena_wsel = cand;
      arena_wbase = r_ff.base_address;
      arena_wheap = r_ff.heap_index;
      arena_wsize = round4(r_ff.byte_count);
      arena_wused = 16'd0;
      arena_wowner = r_ff.node_id;
      used_we = 1'b0;
      used_wsel = map_sel;
      used_wval = al_used;
      case (state_ff)
         S_CLEAR, S_RSWEEP: begin
            mem_we = 1'b1; mem_wa_en = 1'b1; mem_wo_en = 1'b1;
            mem_waddr = cnt_ff[NW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (NW+1)'(NODES - 1)) begin
               if (state_ff == S_CLEAR) state_in = S_IDLE;
               else begin
                  out_in = mk(ST_OK);
                  state_in = S_OUT;
               end
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               r_in = req.payload;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            state_in = S_OUT;
            out_in = mk(ST_OK);
            case (r_ff.operation)
               OP_CREATE: begin
                  if (r_ff.byte_count == 16'd0) out_in = mk(ST_ZERO_SIZE);
                  else if (!node_ok) out_in = mk(ST_BAD_NODE);
                  else if (r_ff.heap_index == HeapFail) out_in = mk(ST_HEAP_FAIL);
                  else begin
                     scan_in = '0;
                     state_in = S_SEARCH;
                  end
               end
               OP_DESTROY: begin
                  if (!sel_ok) out_in = mk(ST_BAD_ARENA);
                  else if (sel == AW'(0)) out_in = mk(ST_ARENA0);
                  else if (owner_ff[sel] != r_ff.node_id) out_in = mk(ST_NOT_OWNER);
                  else begin
                     cnt_in = '0;
                     mem_raddr = '0;
                     state_in = S_SWEEP;
                  end
               end
               OP_SET_ACTIVE, OP_CAPTURE, OP_WR_ARENA, OP_WR_OFFSET, OP_READ_NODE: begin
                  if (!node_ok) out_in = mk(ST_BAD_NODE);
                  else begin
                     mem_waddr = node_ix;
                     case (r_ff.operation)
                        OP_SET_ACTIVE: active_in = amap_rd_ff;
                        OP_CAPTURE: begin
                           mem_we = 1'b1; mem_wa_en = 1'b1; mem_wa = active_ff;
                        end
                        OP_WR_ARENA: begin
                           mem_we = 1'b1; mem_wa_en = 1'b1; mem_wa = r_ff.arena_id;
                        end
                        OP_WR_OFFSET: begin
                           mem_we = 1'b1; mem_wo_en = 1'b1; mem_wo = r_ff.write_value;
                        end
                        default: begin
                           out_in.result_arena = amap_rd_ff;
                           out_in.offset = omap_rd_ff;
                        end
                     endcase
                  end
               end
               OP_ALLOC: begin
                  if (r_ff.byte_count == 16'd0) out_in = mk(ST_ZERO_SIZE);
                  else if (!node_ok) out_in = mk(ST_BAD_NODE);
                  else if (amap_rd_ff == NoArena) out_in = mk(ST_NO_ALLOC);
                  else if (amap_rd_ff >= 8'(ARENAS) || !valid_ff[map_sel])
                     out_in = mk(ST_BAD_ARENA);
                  else if (!al_fits) out_in = mk(ST_EXHAUSTED);
                  else begin
                     mem_we = 1'b1; mem_wo_en = 1'b1; mem_wo = al_off;
                     used_we = 1'b1;
                     out_in.address = al_addr;
                     out_in.offset = al_off;
                     out_in.used_bytes = al_used;
                     out_in.free_bytes = free_of(al_used, size_ff[map_sel]);
                  end
               end
               OP_RESET: begin
                  aidx_in = AW'(1);
                  state_in = S_RSCAN;
               end
               OP_USAGE: begin
                  if (!sel_ok) out_in = mk(ST_BAD_ARENA);
                  else begin
                     out_in.used_bytes = used_ff[sel];
                     out_in.free_bytes = free_of(used_ff[sel], size_ff[sel]);
                  end
               end
               default: ;
            endcase
         end
         S_SEARCH: begin
            if (!valid_ff[cand]) begin
               arena_we = 1'b1;
               valid_in[cand] = 1'b1;
               next_id_in = (cand == AW'(ARENAS - 1)) ? 8'd0 : 8'(cand) + 8'd1;
               mem_we = 1'b1; mem_wa_en = 1'b1; mem_wa = 8'(cand);
               out_in = mk(ST_OK);
               out_in.result_arena = 8'(cand);
               state_in = S_OUT;
            end else if (scan_ff == (AW+1)'(ARENAS - 1)) begin
               out_in = mk(ST_IDS_FULL);
               out_in.free_heap_index = r_ff.heap_index;
               out_in.free_valid = 1'b1;
               state_in = S_OUT;
            end else scan_in = scan_ff + 1'b1;
         end
         S_SWEEP: begin
            // The read address runs one entry ahead of the entry examined.
            mem_raddr = NW'(cnt_ff + 1'b1);
            mem_waddr = cnt_ff[NW-1:0];
            if (cnt_ff < (NW+1)'(bound) && amap_rd_ff == r_ff.arena_id) begin
               mem_we = 1'b1; mem_wa_en = 1'b1; mem_wo_en = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (NW+1)'(NODES - 1)) begin
               if (active_ff == r_ff.arena_id) active_in = NoArena;
               valid_in[sel] = 1'b0;
               out_in = mk(ST_OK);
               out_in.free_heap_index = heap_ff[sel];
               out_in.free_valid = 1'b1;
               state_in = S_OUT;
            end
         end
         S_RSCAN: begin
            aidx_in = (aidx_ff == AW'(ARENAS - 1)) ? '0 : aidx_ff + 1'b1;
            if (valid_ff[aidx_ff]) begin
               valid_in[aidx_ff] = 1'b0;
               out_in = mk(ST_OK);
               out_in.free_heap_index = heap_ff[aidx_ff];
               out_in.free_valid = 1'b1;
               out_in.last = 1'b0;
               state_in = S_OUT;
            end else if (aidx_ff == AW'(ARENAS - 1)) begin
               used_we = 1'b1; used_wsel = '0; used_wval = 16'd0;
               next_id_in = 8'd1;
               active_in = NoArena;
               cnt_in = '0;
               state_in = S_RSWEEP;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               if (out_ff.last) state_in = S_IDLE;
               else if (aidx_ff == AW'(0)) begin
                  used_we = 1'b1; used_wsel = '0; used_wval = 16'd0;
                  next_id_in = 8'd1;
                  active_in = NoArena;
                  cnt_in = '0;
                  state_in = S_RSWEEP;
               end else state_in = S_RSCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
      node_count_in = node_count_ff;
      if (csr.valid && csr.index == CSR_NODE_COUNT) node_count_in = csr.data[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         aidx_ff <= '0;
         scan_ff <= '0;
         node_count_ff <= 9'd256;
         next_id_ff <= 8'd1;
         active_ff <= NoArena;
         valid_ff <= ARENAS'(1);
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         aidx_ff <= aidx_in;
         scan_ff <= scan_in;
         node_count_ff <= node_count_in;
         next_id_ff <= next_id_in;
         active_ff <= active_in;
         valid_ff <= valid_in;
      end
      r_ff <= r_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ARENAS; i++) begin
            base_ff[i] <= 32'd0;
            heap_ff[i] <= 16'd0;
            size_ff[i] <= 16'd0;
            used_ff[i] <= 16'd0;
            owner_ff[i] <= 16'd0;
         end
         size_ff[0] <= 16'd1024;
         owner_ff[0] <= SysOwner;
      end else begin
         if (arena_we) begin
            base_ff[arena_wsel] <= arena_wbase;
            heap_ff[arena_wsel] <= arena_wheap;
            size_ff[arena_wsel] <= arena_wsize;
            used_ff[arena_wsel] <= arena_wused;
            owner_ff[arena_wsel] <= arena_wowner;
         end
         if (used_we) used_ff[used_wsel] <= used_wval;
         if (csr.valid && csr.index == CSR_ARENA0_BASE) base_ff[0] <= csr.data;
         if (csr.valid && csr.index == CSR_ARENA0_SIZE)
            size_ff[0] <= (csr.data[15:0] == 16'd0) ? 16'd4 : round4(csr.data[15:0]);
      end
   end

`ifndef SYNTHESIS
   a_arena0_kept: assert property (@(posedge clock) disable iff (reset) valid_ff[0])
      else $error("arena 0 lost its valid bit");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("request taken while a result is pending");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.payload.last |=> req.ready)
      else $error("not idle after the final result");
`endif
endmodule

@@ src/nabump_align.sv @@
// Shared unit that aligns the bump pointer and checks the arena's room.
module nabump_align (
   input  logic [31:0] base,
   input  logic [15:0] used,
   input  logic [15:0] size,
   input  logic [15:0] req_size,
   input  logic [2:0]  align_log2,
   output logic [31:0] aligned,
   output logic [15:0] off,
   output logic [15:0] new_used,
   output logic        fits
);
   import nabump_pkg::*;
   logic [31:0] cur;
   logic [31:0] mask;
   logic [7:0]  pad;
   logic [17:0] total;

   always_comb begin
      cur      = base + {16'd0, used};
      mask     = (32'd1 << align_log2) - 32'd1;
      aligned  = (cur + mask) & ~mask;
      pad      = 8'(aligned - cur);
      total    = {2'b0, used} + {10'd0, pad} + {2'b0, req_size};
      fits     = total <= {2'b0, size};
      off      = used + {8'd0, pad};
      new_used = total[15:0];
   end
endmodule
